@@ sv/pls_pkg.sv @@
`timescale 1ns / 1ps

package pls_pkg;

    // divider widths: dividend magnitude up to 3 * 2^31, divisor up to 2^32 - 1
    localparam int DVD_W = 33;
    localparam int DVS_W = 32;
    localparam int CNT_W = $clog2(DVD_W + 1);

    // saturation limits, also the "unbounded" slope readout
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [34:0] SAT_HI  = 35'sd2147483647;
    localparam logic signed [34:0] SAT_LO  = -35'sd2147483648;

    // configuration register indexes
    localparam logic REG_ERROR_BOUND  = 1'b0;
    localparam logic REG_SEG_PER_BATCH = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_EVAL,
        ST_EMITC,
        ST_QGO,
        ST_QWT,
        ST_NSEL,
        ST_NWT,
        ST_FIN,
        ST_EMITF
    } t_state;

    typedef struct packed {
        logic signed [31:0] intercept;
        logic signed [31:0] slope_high;
        logic signed [31:0] slope_low;
        logic               slopes_open;
        logic [31:0]        end_index;
        logic               batch_end;
        logic               final_segment;
    } t_out_word;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI) begin
            r = S32_MAX;
        end else if (v < SAT_LO) begin
            r = S32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ sv/pls_ifc.sv @@
`timescale 1ns / 1ps

interface pls_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample;
    logic               last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface pls_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] intercept;
    logic signed [31:0] slope_high;
    logic signed [31:0] slope_low;
    logic               slopes_open;
    logic [31:0]        end_index;
    logic               batch_end;
    logic               final_segment;

    modport source (output valid, output intercept, output slope_high, output slope_low,
                    output slopes_open, output end_index, output batch_end,
                    output final_segment, input ready);
    modport sink   (input valid, input intercept, input slope_high, input slope_low,
                    input slopes_open, input end_index, input batch_end,
                    input final_segment, output ready);
endinterface

@@ sv/piecewise_linear_segmenter_unit.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Handshake         Word
// i_in      in   valid/ready       sample (Q16.16), last_sample
// o_out     out  valid/ready       intercept, slope_high/low, slopes_open,
//                                  end_index, batch_end, final_segment
// i_cfg_*   in   write enable      idx 0 error_bound, idx 1 segments_per_batch
//
// Sequence: one sample at a time. Ordinary sample: the multiply steps and compare,
//   then one pass of the shared divider per slope bound narrowed (a bound that
//   needs no narrowing is skipped). First sample runs one divider pass for
//   intercept quantization; a restart sample emits the closed segment's word and
//   then quantizes. A last sample also emits a flush word.
// The radix-2 divider (one quotient bit per cycle) dominates the time per sample.
// Reset (sync, active low) clears segment state; error_bound = 1.0, batch = 256.
// Output word sits in a register; a stall there only blocks the block when a
//   new word must be loaded while the old one is still unread.
module piecewise_linear_segmenter_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pls_in_if.sink      i_in,
    pls_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [30:0] i_cfg_data
);

    // configuration
    logic [30:0] r_eb;
    logic [15:0] r_spb;

    // segment state
    pls_pkg::t_state    r_state, n_state;
    logic               r_started;
    logic signed [31:0] r_base [2];      // floor, ceil
    logic signed [31:0] r_win  [4];      // floor hi, floor lo, ceil hi, ceil lo
    logic [3:0]         r_fin;
    logic               r_alive_f, r_alive_c;
    logic signed [31:0] r_vote;
    logic [31:0]        r_pos;
    logic [31:0]        r_si;
    logic [15:0]        r_cc;

    // per-sample work
    logic signed [31:0] r_y;
    logic               r_last;
    logic               r_first, r_rst, r_be;
    logic [2:0]         r_idx;
    logic [3:0]         r_gt, r_lt, r_need;

    // output register
    logic                r_ov;
    pls_pkg::t_out_word  r_od;

    logic accept, out_load, div_start, div_done;

    assign accept = i_in.valid && i_in.ready;

    // ---------------- shared arithmetic ----------------
    logic [30:0]        e_eff;
    logic signed [34:0] y_s, e_s;
    logic [2:0]         m_idx3;
    logic [1:0]         m_idx;
    logic signed [34:0] mb, dm, dp;
    logic signed [63:0] mul_p;

    assign e_eff  = (r_eb == '0) ? 31'd1 : r_eb;
    assign y_s    = {{3{r_y[31]}}, r_y};
    assign e_s    = {4'b0, e_eff};
    assign m_idx3 = r_idx - 3'd1;
    assign m_idx  = m_idx3[1:0];
    assign mb     = {{3{r_base[m_idx[1]][31]}}, r_base[m_idx[1]]};
    assign dm     = y_s - mb - e_s;
    assign dp     = y_s - mb + e_s;

    pls_mul u_mul (
        .i_clk (i_clk),
        .i_a   (r_win[r_idx[1:0]]),
        .i_b   (r_pos),
        .o_p   (mul_p)
    );

    logic signed [63:0] dm64, dp64;
    assign dm64 = {{29{dm[34]}}, dm};
    assign dp64 = {{29{dp[34]}}, dp};

    // narrowing numerator for bound r_idx
    logic [1:0]         n_j;
    logic signed [34:0] nb, nn, nmag_s, ymag_s;
    assign n_j    = r_idx[1:0];
    assign nb     = {{3{r_base[n_j[1]][31]}}, r_base[n_j[1]]};
    assign nn     = n_j[0] ? (y_s - e_s - nb) : (y_s + e_s - nb);
    assign nmag_s = nn[34] ? -nn : nn;
    assign ymag_s = y_s[34] ? -y_s : y_s;

    logic                      quant_mode;
    logic [pls_pkg::DVD_W-1:0] div_dvd, div_quo;
    logic [pls_pkg::DVS_W-1:0] div_dvs, div_rem;

    assign quant_mode = (r_state == pls_pkg::ST_QGO) || (r_state == pls_pkg::ST_QWT);
    assign div_dvd = quant_mode ? ymag_s[pls_pkg::DVD_W-1:0] : nmag_s[pls_pkg::DVD_W-1:0];
    assign div_dvs = quant_mode ? {1'b0, e_eff} : r_pos;

    pls_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dvd   (div_dvd),
        .i_dvs   (div_dvs),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    // slope bound from quotient: upper rounds down, lower rounds up
    logic               rem_nz;
    logic signed [34:0] q_s, slope_raw;
    assign rem_nz = div_rem != '0;
    assign q_s    = {2'b0, div_quo};
    always_comb begin
        if (!n_j[0]) begin
            slope_raw = nn[34] ? -(q_s + 35'(rem_nz)) : q_s;
        end else begin
            slope_raw = nn[34] ? -q_s : (q_s + 35'(rem_nz));
        end
    end

    // intercept quantization from floored remainder
    logic [30:0]        rf;
    logic signed [34:0] q_floor, q_ceil;
    assign rf      = (r_y[31] && rem_nz) ? (e_eff - div_rem[30:0]) : div_rem[30:0];
    assign q_floor = y_s - {4'b0, rf};
    assign q_ceil  = q_floor + ((rf != '0) ? e_s : 35'sd0);

    // ---------------- candidate evaluation ----------------
    logic               viol_f, viol_c, fa_n, ca_n, close;
    logic signed [31:0] v1, v2;
    logic [3:0]         need;
    logic [15:0]        cc_inc;
    logic               be;

    assign viol_f = (r_fin[0] && r_gt[0]) || (r_fin[1] && r_lt[1]);
    assign viol_c = (r_fin[2] && r_gt[2]) || (r_fin[3] && r_lt[3]);
    assign fa_n   = r_alive_f && !viol_f;
    assign ca_n   = r_alive_c && !viol_c;
    assign v1     = (fa_n && r_vote != pls_pkg::S32_MAX) ? r_vote + 32'sd1 : r_vote;
    assign v2     = (ca_n && v1 != pls_pkg::S32_MIN) ? v1 - 32'sd1 : v1;
    assign close  = !fa_n && !ca_n;
    assign need   = {!r_fin[3] || r_gt[3], !r_fin[2] || r_lt[2],
                     !r_fin[1] || r_gt[1], !r_fin[0] || r_lt[0]};
    assign cc_inc = r_cc + 16'd1;
    assign be     = cc_inc >= r_spb;

    // result word from current segment state; vote of zero or below picks ceil
    pls_pkg::t_out_word res;
    logic               k, fh, fl;
    always_comb begin
        k  = !(r_vote > 32'sd0);
        fh = r_fin[{k, 1'b0}];
        fl = r_fin[{k, 1'b1}];
        res.intercept     = r_base[k];
        res.slope_high    = fh ? r_win[{k, 1'b0}] : pls_pkg::S32_MAX;
        res.slope_low     = fl ? r_win[{k, 1'b1}] : pls_pkg::S32_MIN;
        res.slopes_open   = !(fh && fl);
        res.end_index     = r_si - 32'd1;
        res.batch_end     = (r_state == pls_pkg::ST_EMITF) ? 1'b1 : r_be;
        res.final_segment = r_state == pls_pkg::ST_EMITF;
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pls_pkg::ST_IDLE:  if (accept) n_state = r_started ? pls_pkg::ST_MUL
                                                                : pls_pkg::ST_QGO;
            pls_pkg::ST_MUL:   if (r_idx == 3'd4) n_state = pls_pkg::ST_EVAL;
            pls_pkg::ST_EVAL:  n_state = close ? pls_pkg::ST_EMITC : pls_pkg::ST_NSEL;
            pls_pkg::ST_EMITC: if (out_load) n_state = pls_pkg::ST_QGO;
            pls_pkg::ST_QGO:   n_state = pls_pkg::ST_QWT;
            pls_pkg::ST_QWT:   if (div_done) n_state = pls_pkg::ST_FIN;
            pls_pkg::ST_NSEL: begin
                if (r_idx == 3'd4) n_state = pls_pkg::ST_FIN;
                else if (r_need[r_idx[1:0]]) n_state = pls_pkg::ST_NWT;
            end
            pls_pkg::ST_NWT:   if (div_done) n_state = pls_pkg::ST_NSEL;
            pls_pkg::ST_FIN:   n_state = r_last ? pls_pkg::ST_EMITF : pls_pkg::ST_IDLE;
            pls_pkg::ST_EMITF: if (out_load) n_state = pls_pkg::ST_IDLE;
            default:           n_state = pls_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        out_load  = ((r_state == pls_pkg::ST_EMITC) || (r_state == pls_pkg::ST_EMITF))
                    && (!r_ov || o_out.ready);
        div_start = (r_state == pls_pkg::ST_QGO)
                    || ((r_state == pls_pkg::ST_NSEL) && (r_idx != 3'd4)
                        && r_need[r_idx[1:0]]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pls_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eb  <= 31'(32'd1 << FRAC_BITS);
            r_spb <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pls_pkg::REG_ERROR_BOUND:   r_eb  <= i_cfg_data;
                pls_pkg::REG_SEG_PER_BATCH: r_spb <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // segment state and work registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_base[0] <= '0;
            r_base[1] <= '0;
            for (int i = 0; i < 4; i++) r_win[i] <= '0;
            r_fin     <= '0;
            r_alive_f <= 1'b1;
            r_alive_c <= 1'b1;
            r_vote    <= '0;
            r_pos     <= 32'd1;
            r_si      <= 32'd1;
            r_cc      <= '0;
            r_idx     <= '0;
            r_first   <= 1'b0;
            r_rst     <= 1'b0;
            r_be      <= 1'b0;
            r_last    <= 1'b0;
        end else begin
            case (r_state)
                pls_pkg::ST_IDLE: begin
                    if (accept) begin
                        r_y     <= i_in.sample;
                        r_last  <= i_in.last_sample;
                        r_first <= !r_started;
                        r_rst   <= 1'b0;
                        r_idx   <= '0;
                    end
                end
                pls_pkg::ST_MUL: begin
                    if (r_idx != 3'd0) begin
                        r_gt[m_idx] <= dm64 > mul_p;
                        r_lt[m_idx] <= dp64 < mul_p;
                    end
                    r_idx <= r_idx + 3'd1;
                end
                pls_pkg::ST_EVAL: begin
                    r_alive_f <= fa_n;
                    r_alive_c <= ca_n;
                    r_vote    <= v2;
                    r_need    <= need;
                    r_rst     <= close;
                    r_idx     <= '0;
                    if (close) begin
                        r_cc <= cc_inc;
                        r_be <= be;
                    end
                end
                pls_pkg::ST_EMITC: begin
                    if (out_load && r_be) begin
                        r_cc <= '0;
                        r_si <= '0;
                    end
                end
                pls_pkg::ST_QWT: begin
                    if (div_done) begin
                        r_base[0] <= pls_pkg::sat32(q_floor);
                        r_base[1] <= pls_pkg::sat32(q_ceil);
                        for (int i = 0; i < 4; i++) r_win[i] <= '0;
                        r_fin     <= '0;
                        r_alive_f <= 1'b1;
                        r_alive_c <= 1'b1;
                        r_vote    <= '0;
                        if (r_first) begin
                            r_pos     <= 32'd1;
                            r_si      <= 32'd1;
                            r_started <= 1'b1;
                        end
                    end
                end
                pls_pkg::ST_NSEL: begin
                    if (r_idx != 3'd4 && !r_need[r_idx[1:0]]) r_idx <= r_idx + 3'd1;
                end
                pls_pkg::ST_NWT: begin
                    if (div_done) begin
                        r_win[n_j] <= pls_pkg::sat32(slope_raw);
                        r_fin[n_j] <= 1'b1;
                        r_idx      <= r_idx + 3'd1;
                    end
                end
                pls_pkg::ST_FIN: begin
                    if (!r_first) begin
                        r_si <= r_si + 32'd1;
                        if (r_rst) r_pos <= 32'd1;
                        else if (r_pos != 32'hFFFF_FFFF) r_pos <= r_pos + 32'd1;
                    end
                end
                pls_pkg::ST_EMITF: begin
                    if (out_load) begin
                        r_started <= 1'b0;
                        r_base[0] <= '0;
                        r_base[1] <= '0;
                        for (int i = 0; i < 4; i++) r_win[i] <= '0;
                        r_fin     <= '0;
                        r_alive_f <= 1'b1;
                        r_alive_c <= 1'b1;
                        r_vote    <= '0;
                        r_pos     <= 32'd1;
                        r_si      <= 32'd1;
                        r_cc      <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) r_od <= res;
    end

    assign i_in.ready          = r_state == pls_pkg::ST_IDLE;
    assign o_out.valid         = r_ov;
    assign o_out.intercept     = r_od.intercept;
    assign o_out.slope_high    = r_od.slope_high;
    assign o_out.slope_low     = r_od.slope_low;
    assign o_out.slopes_open   = r_od.slopes_open;
    assign o_out.end_index     = r_od.end_index;
    assign o_out.batch_end     = r_od.batch_end;
    assign o_out.final_segment = r_od.final_segment;

    // one sample at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_in.ready)
        else $error("input taken again while a sample is in flight");

    // segment offset never reaches zero once a series is running
    a_pos_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |-> (r_pos != 32'd0))
        else $error("segment offset is zero");

    // flush word leaves the segmenter in its unstarted state
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pls_pkg::ST_EMITF && out_load) |=> (!r_started && r_cc == 16'd0))
        else $error("state not cleared after flush");

    // a word is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_out.ready) |-> !out_load)
        else $error("output word overwritten");

endmodule

@@ sv/pls_div.sv @@
`timescale 1ns / 1ps

// radix-2 restoring divider, one quotient bit per cycle
module pls_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pls_pkg::DVD_W-1:0]   i_dvd,
    input  logic [pls_pkg::DVS_W-1:0]   i_dvs,
    output logic                        o_done,
    output logic [pls_pkg::DVD_W-1:0]   o_quo,
    output logic [pls_pkg::DVS_W-1:0]   o_rem
);

    logic                        r_busy;
    logic                        r_done;
    logic [pls_pkg::CNT_W-1:0]   r_cnt;
    logic [pls_pkg::DVD_W-1:0]   r_quo;
    logic [pls_pkg::DVS_W:0]     r_rem;
    logic [pls_pkg::DVS_W-1:0]   r_dvs;
    logic [pls_pkg::DVS_W:0]     trial;
    logic                        ge;

    assign trial = {r_rem[pls_pkg::DVS_W-1:0], r_quo[pls_pkg::DVD_W-1]};
    assign ge    = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= pls_pkg::CNT_W'(pls_pkg::DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == pls_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dvd;
            r_rem <= '0;
            r_dvs <= i_dvs;
        end else if (r_busy) begin
            r_rem <= ge ? (trial - {1'b0, r_dvs}) : trial;
            r_quo <= {r_quo[pls_pkg::DVD_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem[pls_pkg::DVS_W-1:0];

endmodule

@@ sv/pls_mul.sv @@
`timescale 1ns / 1ps

// signed slope times unsigned offset, registered product
module pls_mul (
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic [31:0]        i_b,
    output logic signed [63:0] o_p
);

    logic signed [64:0] prod;
    logic signed [63:0] r_p;

    assign prod = i_a * $signed({1'b0, i_b});

    always_ff @(posedge i_clk) begin
        r_p <= prod[63:0];
    end

    assign o_p = r_p;

endmodule
